### design/stia_pkg.sv
// Shared types, constants and a helper function for the slot table block.
package stia_pkg;

   localparam int SLOT_COUNT  = 8;
   localparam int SLOT_IDX_W  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int ACTION_W    = 2;
   localparam int KEY_W       = 32;
   localparam int DUE_W       = 32;
   localparam int SLOT_USED_W = 3;

   typedef logic [ACTION_W-1:0]   action_type;
   typedef logic [KEY_W-1:0]      key_type;
   typedef logic [DUE_W-1:0]      due_type;
   typedef logic [SLOT_IDX_W-1:0] slot_idx_type;
   typedef logic [SLOT_COUNT-1:0] slot_vec_type;

   localparam action_type ACT_ADD    = 2'd0;
   localparam action_type ACT_MARK   = 2'd1;
   localparam action_type ACT_REMOVE = 2'd2;

   localparam key_type KEY_FIRST = key_type'(1);

   // controller -> datapath
   typedef struct packed {
      logic capture;   // latch the request beat
      logic commit;    // execute and load the result register
   } dp_cmd_type;

   typedef struct packed {
      logic         found;
      slot_idx_type idx;
   } slot_pick_type;

   // lowest set bit wins
   function automatic slot_pick_type pick_lowest(input slot_vec_type hits);
      slot_pick_type pick;
      pick.found = 1'b0;
      pick.idx   = '0;
      for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
         if (hits[i]) begin
            pick.found = 1'b1;
            pick.idx   = slot_idx_type'(i);
         end
      end
      return pick;
   endfunction

endpackage

### design/stia_if.sv
// Request and response channel interfaces.
interface stia_req_if;
   logic                 valid;
   logic                 ready;
   stia_pkg::action_type action;
   stia_pkg::due_type    due_time;
   logic                 text_nonempty;
   stia_pkg::key_type    entry_key;

   modport source (output valid, action, due_time, text_nonempty, entry_key, input ready);
   modport sink   (input valid, action, due_time, text_nonempty, entry_key, output ready);
endinterface

interface stia_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic                                 ok;
   stia_pkg::key_type                    new_key;
   logic [stia_pkg::SLOT_USED_W-1:0]     slot_used;
   stia_pkg::due_type                    new_due;

   modport source (output valid, ok, new_key, slot_used, new_due, input ready);
   modport sink   (input valid, ok, new_key, slot_used, new_due, output ready);
endinterface

### design/stia_ctrl.sv
// Controller: sequences capture and execute, owns the response valid flag.
module stia_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output stia_pkg::dp_cmd_type cmd
);

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in    = state_ff;
      cmd.capture = 1'b0;
      cmd.commit  = 1'b0;
      req_ready   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
            if (req_valid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            // result register free, or emptied this cycle
            cmd.commit = !rsp_valid_ff || rsp_ready;
            if (cmd.commit) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      rsp_valid_in = cmd.commit ? 1'b1 : (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

### design/stia_dp.sv
// Datapath: request register, slot table, parallel slot search, result register.
module stia_dp (
   input  logic                              clock,
   input  logic                              reset,
   input  stia_pkg::dp_cmd_type              cmd,
   input  stia_pkg::action_type              req_action,
   input  stia_pkg::due_type                 req_due_time,
   input  logic                              req_text_nonempty,
   input  stia_pkg::key_type                 req_entry_key,
   output logic                              rsp_ok,
   output stia_pkg::key_type                 rsp_new_key,
   output logic [stia_pkg::SLOT_USED_W-1:0]  rsp_slot_used,
   output stia_pkg::due_type                 rsp_new_due
);

   // request register
   stia_pkg::action_type action_ff;
   stia_pkg::due_type    due_ff;
   logic                 text_ff;
   stia_pkg::key_type    key_ff;

   // slot table; the due time is only echoed back, so no copy is held
   stia_pkg::key_type    slot_key_ff [stia_pkg::SLOT_COUNT];
   stia_pkg::slot_vec_type slot_active_ff, slot_active_in;
   stia_pkg::slot_vec_type slot_done_ff, slot_done_in;
   stia_pkg::key_type    next_key_ff, next_key_in;

   // result register
   logic                             ok_ff, ok_in;
   stia_pkg::key_type                new_key_ff, new_key_in;
   logic [stia_pkg::SLOT_USED_W-1:0] slot_used_ff, slot_used_in;
   stia_pkg::due_type                new_due_ff, new_due_in;

   stia_pkg::slot_vec_type  match_hits;
   stia_pkg::slot_pick_type free_pick, done_pick, match_pick, add_pick;
   stia_pkg::key_type       key_inc;
   logic                    write_key;
   stia_pkg::slot_idx_type  tgt_idx;
   stia_pkg::key_type       write_val;

   always_comb begin
      for (int i = 0; i < stia_pkg::SLOT_COUNT; i++) begin
         match_hits[i] = slot_active_ff[i] && (slot_key_ff[i] == key_ff);
      end
      free_pick  = stia_pkg::pick_lowest(~slot_active_ff);
      done_pick  = stia_pkg::pick_lowest(slot_done_ff);
      match_pick = stia_pkg::pick_lowest(match_hits);
      add_pick   = free_pick.found ? free_pick : done_pick;
      key_inc    = next_key_ff + stia_pkg::KEY_FIRST;
   end

   always_comb begin
      slot_active_in = slot_active_ff;
      slot_done_in   = slot_done_ff;
      next_key_in    = next_key_ff;
      ok_in          = 1'b0;
      new_key_in     = '0;
      slot_used_in   = '0;
      new_due_in     = '0;
      write_key      = 1'b0;
      tgt_idx        = '0;
      write_val      = '0;
      case (action_ff)
         stia_pkg::ACT_ADD: begin
            if ((due_ff != '0) && text_ff && add_pick.found) begin
               tgt_idx                 = add_pick.idx;
               write_key               = 1'b1;
               write_val               = next_key_ff;
               slot_active_in[tgt_idx] = 1'b1;
               slot_done_in[tgt_idx]   = 1'b0;
               next_key_in             = (key_inc == '0) ? stia_pkg::KEY_FIRST : key_inc;
               ok_in                   = 1'b1;
               new_key_in              = next_key_ff;
               slot_used_in            = stia_pkg::SLOT_USED_W'(tgt_idx);
               new_due_in              = due_ff;
            end
         end
         stia_pkg::ACT_MARK: begin
            tgt_idx = match_pick.idx;
            if (match_pick.found && !slot_done_ff[tgt_idx]) begin
               slot_done_in[tgt_idx] = 1'b1;
               ok_in                 = 1'b1;
               slot_used_in          = stia_pkg::SLOT_USED_W'(tgt_idx);
            end
         end
         stia_pkg::ACT_REMOVE: begin
            tgt_idx = match_pick.idx;
            if (match_pick.found) begin
               write_key               = 1'b1;
               slot_active_in[tgt_idx] = 1'b0;
               slot_done_in[tgt_idx]   = 1'b0;
               ok_in                   = 1'b1;
               slot_used_in            = stia_pkg::SLOT_USED_W'(tgt_idx);
            end
         end
         default: ok_in = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         action_ff <= req_action;
         due_ff    <= req_due_time;
         text_ff   <= req_text_nonempty;
         key_ff    <= req_entry_key;
      end
      if (cmd.commit) begin
         if (write_key) begin
            slot_key_ff[tgt_idx] <= write_val;
         end
         ok_ff        <= ok_in;
         new_key_ff   <= new_key_in;
         slot_used_ff <= slot_used_in;
         new_due_ff   <= new_due_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_active_ff <= '0;
         slot_done_ff   <= '0;
         next_key_ff    <= stia_pkg::KEY_FIRST;
      end else if (cmd.commit) begin
         slot_active_ff <= slot_active_in;
         slot_done_ff   <= slot_done_in;
         next_key_ff    <= next_key_in;
      end
   end

   assign rsp_ok        = ok_ff;
   assign rsp_new_key   = new_key_ff;
   assign rsp_slot_used = slot_used_ff;
   assign rsp_new_due   = new_due_ff;

endmodule

### design/slot_table_with_id_allocation_unit.sv
// Capture latches a request beat; execute then loads the result register once it
//   is free. The controller takes no new request while executing, but the next one
//   is taken while a response still waits in the result register.
// Reset (synchronous, active high): all slots inactive and not completed, id
//   counter back to one, no response pending; effective on the next cycle.
// Top level: slot table with id allocation.
module slot_table_with_id_allocation_unit (
   input logic       clock,
   input logic       reset,
   stia_req_if.sink   req_bus,
   stia_rsp_if.source rsp_bus
);

   stia_pkg::dp_cmd_type cmd;

   // sequencing: idle -> execute, response valid kept as its own flag
   stia_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .cmd       (cmd)
   );

   // table, free-slot and id-match search, result register
   stia_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .req_action        (req_bus.action),
      .req_due_time      (req_bus.due_time),
      .req_text_nonempty (req_bus.text_nonempty),
      .req_entry_key     (req_bus.entry_key),
      .rsp_ok            (rsp_bus.ok),
      .rsp_new_key       (rsp_bus.new_key),
      .rsp_slot_used     (rsp_bus.slot_used),
      .rsp_new_due       (rsp_bus.new_due)
   );

endmodule
